/* design/s2a_pkg.sv */
// Shared types, scan code constants and key maps for the scan code to ASCII FIFO.
// No dependencies.
package s2a_pkg;

   localparam logic [7:0] CODE_SHIFT_L_UP   = 8'hAA;
   localparam logic [7:0] CODE_SHIFT_R_UP   = 8'hB6;
   localparam int         CODE_RELEASE_BIT  = 7;
   localparam logic [7:0] CODE_SHIFT_L_DOWN = 8'h2A;
   localparam logic [7:0] CODE_SHIFT_R_DOWN = 8'h36;
   localparam logic [7:0] CODE_CAPS_DOWN    = 8'h3A;
   localparam logic [7:0] MAP_LIMIT         = 8'd58;
   localparam logic [7:0] CASE_OFFSET       = 8'd32;
   localparam logic [7:0] CHAR_LOWER_A      = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z      = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A      = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z      = 8'h5A;

   localparam logic CMD_CODE = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam int MAP_SIZE = 64;

   // entries 58 and up may be looked up but are never pushed
   localparam logic [7:0] PLAIN_MAP [0:MAP_SIZE-1] = '{
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] SHIFTED_MAP [0:MAP_SIZE-1] = '{
      8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
      8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   typedef struct packed {
      logic       push;
      logic [7:0] ch;
   } decode_type;

   typedef struct packed {
      logic       adv;
      logic       push;
      logic       pop;
      logic [7:0] ch;
   } fifo_ctrl_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic       read_valid;
      logic       not_empty;
      logic       char_dropped;
   } fifo_stat_type;

endpackage

/* design/s2a_if.sv */
// Valid/ready channel interfaces for request and response items.
// No dependencies.
interface s2a_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] scancode;

   modport source (output valid, output cmd, output scancode, input ready);
   modport sink (input valid, input cmd, input scancode, output ready);
endinterface

interface s2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_char;
   logic       read_valid;
   logic       not_empty;
   logic       shift_held;
   logic       caps_on;
   logic       char_dropped;

   modport source (output valid, output read_char, output read_valid, output not_empty,
                   output shift_held, output caps_on, output char_dropped, input ready);
   modport sink (input valid, input read_char, input read_valid, input not_empty,
                 input shift_held, input caps_on, input char_dropped, output ready);
endinterface

/* design/scancode_to_ascii_fifo_top.sv */
// Top level: scan code to ASCII decoder with character FIFO.
// Depends on s2a_pkg, s2a_if, s2a_decode, s2a_fifo.
//
//   channel  dir  payload                                             handshake
//   req_ch   in   cmd, scancode                                       valid/ready
//   rsp_ch   out  read_char, read_valid, not_empty, shift_held,       valid/ready
//                 caps_on, char_dropped
//
// One item per cycle while rsp_ch is ready; an item passes the input register, then
// decode and one FIFO access into the result register, read data from FIFO memory port.
// Synchronous active-high reset clears pointers, modifiers and valids; no clear pass.
// A stalled result holds both stages; the input stage takes an item whenever it can move.
module scancode_to_ascii_fifo_top #(
   parameter int FIFO_DEPTH = 128
) (
   input  logic             clock,
   input  logic             reset,
   s2a_req_if.sink          req_ch,
   s2a_rsp_if.source        rsp_ch
);

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_cmd_ff;
   logic [7:0]             s1_code_ff;
   logic                   out_valid_ff, out_valid_in;
   logic                   adv;
   s2a_pkg::decode_type    dec;
   s2a_pkg::fifo_ctrl_type fctrl;
   s2a_pkg::fifo_stat_type fstat;
   logic                   shift_held, caps_on;

   always_comb begin
      adv          = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
      req_ch.ready = !s1_valid_ff || adv;
      s1_valid_in  = req_ch.valid ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
      out_valid_in = adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      fctrl.adv    = adv;
      fctrl.push   = (s1_cmd_ff == s2a_pkg::CMD_CODE) && dec.push;
      fctrl.pop    = (s1_cmd_ff == s2a_pkg::CMD_READ);
      fctrl.ch     = dec.ch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= s1_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_cmd_ff  <= req_ch.cmd;
         s1_code_ff <= req_ch.scancode;
      end
   end

   s2a_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .fire       (adv && (s1_cmd_ff == s2a_pkg::CMD_CODE)),
      .scancode   (s1_code_ff),
      .dec        (dec),
      .shift_held (shift_held),
      .caps_on    (caps_on)
   );

   s2a_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .ctrl  (fctrl),
      .stat  (fstat)
   );

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.read_char    = fstat.read_char;
   assign rsp_ch.read_valid   = fstat.read_valid;
   assign rsp_ch.not_empty    = fstat.not_empty;
   assign rsp_ch.shift_held   = shift_held;
   assign rsp_ch.caps_on      = caps_on;
   assign rsp_ch.char_dropped = fstat.char_dropped;

endmodule

/* design/s2a_decode.sv */
// Scan code decoder: shift/caps modifier state and key map lookup.
// Depends on s2a_pkg.
module s2a_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         scancode,
   output s2a_pkg::decode_type dec,
   output logic               shift_held,
   output logic               caps_on
);

   logic       shift_ff, shift_in;
   logic       caps_ff, caps_in;
   logic [7:0] map_ch;
   logic [7:0] case_ch;
   logic       is_shift_up, is_release, is_shift_down, is_caps, mapped;

   always_comb begin
      is_shift_up   = (scancode == s2a_pkg::CODE_SHIFT_L_UP) ||
                      (scancode == s2a_pkg::CODE_SHIFT_R_UP);
      is_release    = scancode[s2a_pkg::CODE_RELEASE_BIT];
      is_shift_down = (scancode == s2a_pkg::CODE_SHIFT_L_DOWN) ||
                      (scancode == s2a_pkg::CODE_SHIFT_R_DOWN);
      is_caps       = (scancode == s2a_pkg::CODE_CAPS_DOWN);
      mapped        = !is_release && !is_shift_down && !is_caps &&
                      (scancode < s2a_pkg::MAP_LIMIT);

      map_ch = shift_ff ? s2a_pkg::SHIFTED_MAP[scancode[5:0]]
                        : s2a_pkg::PLAIN_MAP[scancode[5:0]];
      case_ch = map_ch;
      if (caps_ff && !shift_ff && map_ch >= s2a_pkg::CHAR_LOWER_A &&
          map_ch <= s2a_pkg::CHAR_LOWER_Z) begin
         case_ch = map_ch - s2a_pkg::CASE_OFFSET;
      end else if (caps_ff && shift_ff && map_ch >= s2a_pkg::CHAR_UPPER_A &&
                   map_ch <= s2a_pkg::CHAR_UPPER_Z) begin
         case_ch = map_ch + s2a_pkg::CASE_OFFSET;
      end

      dec.push = mapped && (case_ch != 8'd0);
      dec.ch   = case_ch;

      shift_in = shift_ff;
      caps_in  = caps_ff;
      if (is_shift_up) begin
         shift_in = 1'b0;
      end else if (!is_release && is_shift_down) begin
         shift_in = 1'b1;
      end else if (!is_release && is_caps) begin
         caps_in = !caps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
      end else if (fire) begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
      end
   end

   assign shift_held = shift_ff;
   assign caps_on    = caps_ff;

endmodule

/* design/s2a_fifo.sv */
// Character ring FIFO holding up to FIFO_DEPTH - 1 items, registered read data.
// Depends on s2a_pkg.
module s2a_fifo #(
   parameter int FIFO_DEPTH = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  s2a_pkg::fifo_ctrl_type ctrl,
   output s2a_pkg::fifo_stat_type stat
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [7:0]       char_store [0:FIFO_DEPTH-1];
   logic [PTR_W-1:0] wptr_ff, wptr_in, wptr_nxt;
   logic [PTR_W-1:0] rptr_ff, rptr_in, rptr_nxt;
   logic [7:0]       rd_char_ff;
   logic             rd_valid_ff, rd_valid_in;
   logic             dropped_ff, dropped_in;
   logic             empty, full, do_write;

   always_comb begin
      wptr_nxt    = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
      rptr_nxt    = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
      empty       = (wptr_ff == rptr_ff);
      full        = (wptr_nxt == rptr_ff);
      do_write    = ctrl.adv && ctrl.push && !full;
      rd_valid_in = ctrl.pop && !empty;
      dropped_in  = ctrl.push && full;
      wptr_in     = do_write ? wptr_nxt : wptr_ff;
      rptr_in     = (ctrl.adv && rd_valid_in) ? rptr_nxt : rptr_ff;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         char_store[wptr_ff] <= ctrl.ch;
      end
      if (ctrl.adv) begin
         rd_char_ff <= rd_valid_in ? char_store[rptr_ff] : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff     <= '0;
         rptr_ff     <= '0;
         rd_valid_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         if (ctrl.adv) begin
            rd_valid_ff <= rd_valid_in;
            dropped_ff  <= dropped_in;
         end
      end
   end

   assign stat.read_char    = rd_char_ff;
   assign stat.read_valid   = rd_valid_ff;
   assign stat.not_empty    = !empty;
   assign stat.char_dropped = dropped_ff;

   a_pop_drop_excl: assert property (@(posedge clock) disable iff (reset)
      !(rd_valid_ff && dropped_ff)) else $error("pop and drop in one item");
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (ctrl.adv && ctrl.pop && empty) |=> (!rd_valid_ff && $stable(rptr_ff)))
      else $error("pop from empty FIFO");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (ctrl.adv && ctrl.push && full) |=> (dropped_ff && $stable(wptr_ff)))
      else $error("write into full FIFO");
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wptr_ff <= PTR_LAST) && (rptr_ff <= PTR_LAST)) else $error("pointer out of range");

endmodule
